// File: rtl/core/command_line_tokenizer_assert.svh
// assertion macros for the command line tokenizer
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// next-cycle implication, sampled on clk, off during reset
`define CLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// File: rtl/core/clt_pkg.sv
`default_nettype none

package clt_pkg;

  localparam int CLT_MAX_CAPACITY = 4096;
  localparam int CFG_W            = 13;
  localparam logic [CFG_W-1:0] CAP_RESET = 13'd256;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    M_SEP   = 3'd0,
    M_BARE  = 3'd1,
    M_QIN   = 3'd2,
    M_QMARK = 3'd3,
    M_DROP  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    K_BYTE = 2'd0,
    K_END  = 2'd1,
    K_EOL  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OVER  = 2'd2,
    ST_ILL   = 2'd3
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    status_t    status;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/command_line_tokenizer.sv
// command line tokenizer
// in channel: one line byte per word (in_valid / in_stall). bytes above 0x20 form
//   tokens, spaces split them, a double quote opens a quoted token, any byte
//   below 0x20 ends the line.
// out channel: one result word per handshake (out_valid / out_stall): token byte,
//   end of token, or end of line with a status. last_of_run marks the final
//   word caused by one input byte; one byte causes zero, one or two words.
// cfg channel: cfg_valid / cfg_ready writes buffer_capacity; cfg_ready is always
//   high. write only while the block is idle.
// the words for a byte are written into the result queue when the byte is taken.
// throughput: one byte per cycle while in_stall is low; a four-entry result queue
//   takes up to two words per cycle and drains one; in_stall rises while more
//   than two words are queued, so bytes making two words settle at that drain rate.
// reset: synchronous, active low; empties the queue, returns to line start with
//   nothing stored and capacity 256.
// when out_stall is high the head word holds; the queue fills and then in_stall
//   holds off new bytes until words are taken.
`default_nettype none

`include "command_line_tokenizer_assert.svh"

module command_line_tokenizer #(
  parameter int MAX_CAPACITY = clt_pkg::CLT_MAX_CAPACITY
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_line_byte,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     out_item_kind,
  output logic [7:0]                     out_token_char,
  output logic [1:0]                     out_line_status,
  output logic                           out_last_of_run,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [clt_pkg::CFG_W-1:0] cfg_buffer_capacity
);
  import clt_pkg::*;

  localparam int CNT_W = $clog2(MAX_CAPACITY + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;

  logic [CFG_W-1:0] cap_r;
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             seen_r, seen_nxt;
  status_t          err_r, err_nxt;

  result_t          q_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_r, rd_r;
  logic [Q_AW:0]    cnt_r, cnt_nxt;

  logic             in_acc, out_acc;
  logic [CMP_W-1:0] cap_ext, max_ext, cap_eff;
  logic             full;
  logic             do_store, do_end, is_eol;
  logic [7:0]       store_ch;
  logic             a_v;
  result_t          a_res, e_res;
  logic [Q_AW-1:0]  wr_e;
  logic [1:0]       push_n;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = cnt_r > (Q_AW+1)'(2);
  assign out_valid = cnt_r != '0;
  assign cfg_ready = 1'b1;

  assign cap_ext = CMP_W'(cap_r);
  assign max_ext = CMP_W'(MAX_CAPACITY);
  assign cap_eff = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign full    = CMP_W'(used_r) >= cap_eff;
  assign is_eol  = in_line_byte < CH_SPACE;

  // per-byte scan
  always_comb begin
    mode_nxt = mode_r;
    used_nxt = used_r;
    seen_nxt = seen_r;
    err_nxt  = err_r;
    do_store = 1'b0;
    do_end   = 1'b0;
    store_ch = in_line_byte;
    a_v      = 1'b0;
    a_res    = '{kind: K_BYTE, ch: in_line_byte, status: ST_OK, last: 1'b0};
    case (mode_r)
      M_BARE: begin
        if (in_line_byte > CH_SPACE) begin
          do_store = 1'b1;
        end else begin
          do_end   = 1'b1;
          mode_nxt = M_SEP;
        end
      end
      M_QIN: begin
        if (is_eol) begin
          err_nxt  = ST_ILL;
          mode_nxt = M_DROP;
        end else if (in_line_byte == CH_QUOTE) begin
          mode_nxt = M_QMARK;
        end else begin
          do_store = 1'b1;
        end
      end
      M_QMARK: begin
        if (in_line_byte == CH_QUOTE) begin
          do_store = 1'b1;
          store_ch = CH_QUOTE;
          mode_nxt = M_QIN;
        end else if (in_line_byte <= CH_SPACE) begin
          do_end   = 1'b1;
          mode_nxt = M_SEP;
        end else begin
          err_nxt  = ST_ILL;
          mode_nxt = M_DROP;
        end
      end
      M_DROP: begin
        mode_nxt = M_DROP;
      end
      default: begin
        mode_nxt = M_SEP;
        if (in_line_byte > CH_SPACE) begin
          seen_nxt = 1'b1;
          if (in_line_byte == CH_QUOTE) begin
            if (full) begin
              err_nxt  = ST_OVER;
              mode_nxt = M_DROP;
            end else begin
              mode_nxt = M_QIN;
            end
          end else begin
            mode_nxt = M_BARE;
            do_store = 1'b1;
          end
        end
      end
    endcase

    if (do_store || do_end) begin
      if (full) begin
        err_nxt  = ST_OVER;
        mode_nxt = M_DROP;
      end else begin
        used_nxt = used_r + CNT_W'(1);
        a_v      = 1'b1;
        a_res.kind = do_end ? K_END : K_BYTE;
        a_res.ch   = do_end ? CH_NUL : store_ch;
      end
    end
    a_res.last = !is_eol;

    e_res = '{kind: K_EOL, ch: CH_NUL, status: ST_OK, last: 1'b1};
    if (err_nxt != ST_OK) begin
      e_res.status = err_nxt;
    end else if (!seen_nxt) begin
      e_res.status = ST_EMPTY;
    end
    if (is_eol) begin
      mode_nxt = M_SEP;
      used_nxt = '0;
      seen_nxt = 1'b0;
      err_nxt  = ST_OK;
    end
  end

  assign wr_e   = wr_r + Q_AW'(a_v);
  assign push_n = in_acc ? (2'(a_v) + 2'(is_eol)) : 2'd0;
  assign cnt_nxt = cnt_r + (Q_AW+1)'(push_n) - (Q_AW+1)'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      mode_r <= M_SEP;
      used_r <= '0;
      seen_r <= 1'b0;
      err_r  <= ST_OK;
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_buffer_capacity;
      end
      if (in_acc) begin
        mode_r <= mode_nxt;
        used_r <= used_nxt;
        seen_r <= seen_nxt;
        err_r  <= err_nxt;
        wr_r   <= wr_r + Q_AW'(push_n);
      end
      if (out_acc) begin
        rd_r <= rd_r + Q_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_acc && a_v) begin
      q_r[wr_r] <= a_res;
    end
    if (in_acc && is_eol) begin
      q_r[wr_e] <= e_res;
    end
  end

  assign out_item_kind   = q_r[rd_r].kind;
  assign out_token_char  = q_r[rd_r].ch;
  assign out_line_status = q_r[rd_r].status;
  assign out_last_of_run = q_r[rd_r].last;

  `CLT_ASSERT_NEXT(a_eol_clears, in_acc && is_eol, used_r == '0 && mode_r == M_SEP && !seen_r)
  `CLT_ASSERT_NEXT(a_drop_silent, in_acc && mode_r == M_DROP && !is_eol,
                   cnt_r <= $past(cnt_r))
  `CLT_ASSERT_NOW(a_eol_last, out_valid && out_item_kind == K_EOL, out_last_of_run)
  `CLT_ASSERT_NOW(a_status_eol_only, out_valid && out_item_kind != K_EOL,
                  out_line_status == ST_OK)

endmodule

`default_nettype wire

// File: test/command_line_tokenizer_test.sv
module command_line_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import clt_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_BYTES = 75;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_line_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_item_kind;
  logic [7:0]       out_token_char;
  logic [1:0]       out_line_status;
  logic             out_last_of_run;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_buffer_capacity = CAP_RESET;

  command_line_tokenizer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_line_byte        (in_line_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_item_kind       (out_item_kind),
    .out_token_char      (out_token_char),
    .out_line_status     (out_line_status),
    .out_last_of_run     (out_last_of_run),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_buffer_capacity (cfg_buffer_capacity)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // tokenizer state as the block should hold it
  mode_t            scan_state = M_SEP;
  int unsigned      bytes_used = 0;
  bit               any_token = 1'b0;
  status_t          line_error = ST_OK;
  logic [CFG_W-1:0] capacity_reg = CAP_RESET;
  result_t          expected_words[$];

  logic [7:0]  pending_bytes[$];
  int unsigned bytes_planned = 0;
  int unsigned bytes_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_level = 0;
  int unsigned stall_level = 0;
  int unsigned send_wait = 0;
  int unsigned stall_left = 0;
  int unsigned recv_hold = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned room_limit();
    return (capacity_reg > CLT_MAX_CAPACITY) ? CLT_MAX_CAPACITY : int'(capacity_reg);
  endfunction

  function automatic void add_word(kind_t k, logic [7:0] c, status_t s);
    result_t w;
    w.kind = k;
    w.ch = c;
    w.status = s;
    w.last = 1'b0;
    expected_words = {expected_words, w};
  endfunction

  function automatic void abort_line(status_t code);
    line_error = code;
    scan_state = M_DROP;
  endfunction

  function automatic bit keep_char(logic [7:0] c);
    if (bytes_used >= room_limit()) begin
      abort_line(ST_OVER);
      return 1'b0;
    end
    bytes_used++;
    add_word(K_BYTE, c, ST_OK);
    return 1'b1;
  endfunction

  function automatic void close_token();
    if (bytes_used >= room_limit()) begin
      abort_line(ST_OVER);
      return;
    end
    bytes_used++;
    add_word(K_END, 8'h00, ST_OK);
    scan_state = M_SEP;
  endfunction

  function automatic void tokenize_byte(logic [7:0] b);
    int unsigned n_prior;
    status_t     eol_status;
    n_prior = expected_words.size();
    case (scan_state)
      M_BARE: begin
        if (b > CH_SPACE) void'(keep_char(b));
        else close_token();
      end
      M_QIN: begin
        if (b < CH_SPACE) abort_line(ST_ILL);
        else if (b == CH_QUOTE) scan_state = M_QMARK;
        else void'(keep_char(b));
      end
      M_QMARK: begin
        if (b == CH_QUOTE) begin
          if (keep_char(CH_QUOTE)) scan_state = M_QIN;
        end else if (b <= CH_SPACE) begin
          close_token();
        end else begin
          abort_line(ST_ILL);
        end
      end
      M_DROP: begin
      end
      default: begin
        scan_state = M_SEP;
        if (b > CH_SPACE) begin
          any_token = 1'b1;
          if (b == CH_QUOTE) begin
            if (bytes_used >= room_limit()) abort_line(ST_OVER);
            else scan_state = M_QIN;
          end else begin
            scan_state = M_BARE;
            void'(keep_char(b));
          end
        end
      end
    endcase
    if (b < CH_SPACE) begin
      if (line_error != ST_OK) eol_status = line_error;
      else if (any_token) eol_status = ST_OK;
      else eol_status = ST_EMPTY;
      add_word(K_EOL, 8'h00, eol_status);
      scan_state = M_SEP;
      bytes_used = 0;
      any_token = 1'b0;
      line_error = ST_OK;
    end
    if (expected_words.size() > n_prior)
      expected_words[expected_words.size()-1].last = 1'b1;
  endfunction

  function automatic int unsigned gap_len(int unsigned level);
    int unsigned r;
    if (level == 0) return 0;
    r = $urandom_range(0, 99);
    if (level == 1) begin
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_byte(in_line_byte);
        bytes_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_line_byte <= pending_bytes.pop_front();
          send_wait = gap_len(send_level);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind = kind_t'(out_item_kind);
        got.ch = out_token_char;
        got.status = status_t'(out_line_status);
        got.last = out_last_of_run;
        if (expected_words.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected word: kind %0d char %h status %0d last %0b",
                   $time, got.kind, got.ch, got.status, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t mismatch: expected kind %0d char %h status %0d last %0b",
                     $time, want.kind, want.ch, want.status, want.last);
            $display("%0t            actual kind %0d char %h status %0d last %0b",
                     $time, got.kind, got.ch, got.status, got.last);
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        recv_hold = LONG_HOLD;
      end
      if (recv_hold > 0) recv_hold--;
      else if (stall_left > 0) stall_left--;
      else stall_left = gap_len(stall_level);
      out_stall <= (recv_hold > 0) || (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(logic [7:0] b);
    pending_bytes = {pending_bytes, b};
    bytes_planned++;
  endtask

  function automatic logic [7:0] plain_char(logic [7:0] lo);
    logic [7:0] c;
    c = 8'($urandom_range(lo, 8'hFE));
    return (c == CH_QUOTE) ? 8'hFF : c;
  endfunction

  // mostly well-formed lines, some noise and some broken quoting
  task automatic queue_line(bit finish_line);
    int unsigned pick;
    int unsigned n_tok;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(0, 255)));
    end else begin
      n_tok = $urandom_range(0, 4);
      for (int t = 0; t < n_tok; t++) begin
        repeat ($urandom_range((t == 0) ? 0 : 1, 3)) queue_byte(CH_SPACE);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        if ($urandom_range(0, 2) == 0) begin
          queue_byte(CH_QUOTE);
          repeat (len) begin
            if ($urandom_range(0, 7) == 0) begin
              queue_byte(CH_QUOTE);
              queue_byte(CH_QUOTE);
            end else begin
              queue_byte(plain_char(CH_SPACE));
            end
          end
          if (pick >= 15 || $urandom_range(0, 1) == 0) queue_byte(CH_QUOTE);
          if (pick >= 15 && pick < 20) queue_byte(plain_char(8'h21));
        end else begin
          queue_byte(plain_char(8'h21));
          repeat (len) queue_byte(8'($urandom_range(8'h21, 8'hFF)));
        end
      end
      repeat ($urandom_range(0, 2)) queue_byte(CH_SPACE);
    end
    if (finish_line) queue_byte(8'($urandom_range(0, 8'h1F)));
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (bytes_taken != bytes_planned || expected_words.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_buffer_capacity <= v;
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0]       opening_bytes[29];
    logic [CFG_W-1:0] phase_caps[12];
    int unsigned      phase_start;
    opening_bytes = '{
      8'h61, 8'h22, 8'h62, 8'h20, 8'h22, 8'h63, 8'h20, 8'h22, 8'h22, 8'h64, 8'h22, 8'h20,
      8'h0A,
      8'h00,
      8'h22, 8'h78, 8'h22, 8'h79, 8'h1F,
      8'h22, 8'hFF, 8'h0D,
      8'h20, 8'h80, 8'h7F, 8'h21, 8'h22, 8'h22, 8'h0A
    };
    phase_caps = '{13'd1, 13'd2, 13'd3, 13'd0, 13'd5, 13'd8, 13'd4096, 13'd8191,
                   13'd0, 13'd0, 13'd0, 13'd256};
    phase_caps[8] = CFG_W'($urandom_range(1, 64));
    phase_caps[9] = CFG_W'($urandom_range(1, 64));
    phase_caps[10] = CFG_W'($urandom_range(1, 8191));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_bytes[i]) queue_byte(opening_bytes[i]);
    wait_drained();

    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      if (phase_caps[p] == 13'd4096 || p == 0) begin
        send_level = 0;
        stall_level = 0;
      end else begin
        send_level = $urandom_range(0, 2);
        stall_level = $urandom_range(0, 2);
      end
      phase_start = bytes_planned;
      while (bytes_planned - phase_start < PHASE_BYTES) queue_line(1'b1);
      if (phase_caps[p] == 13'd4096) hold_requests++;
      if (p != 11 && $urandom_range(0, 1) == 0) queue_line(1'b0);
      wait_drained();
    end

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
